// File: rtl/v32vd_pkg.sv
// ----------------------------------------------------------------------------
// v32vd_pkg
// Shared types, constants and tables of the trellis symbol decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package v32vd_pkg;
  localparam int TRACEBACK_LEN = 16;
  localparam int STATE_COUNT = 8;
  localparam int STATE_W = 3;
  localparam int PATH_W = 3 * TRACEBACK_LEN;
  localparam int LEN_W = 24;
  localparam logic [LEN_W-1:0] LEN_INF = '1;
  localparam int DIST_W = 36;

  localparam logic [0:0] REG_RATE_MODE = 1'd0;
  localparam logic [0:0] REG_DECAY = 1'd1;

  typedef struct packed {
    logic start;
    logic coded;
    logic [STATE_W-1:0] src;
    logic acs_en;
    logic commit;
  } v32vd_cmd_t;

  typedef struct packed {
    logic [2:0] bits;
    logic [2:0] pre;
    logic [2:0] pim;
  } v32vd_res_t;

  // 16-point constellation, {re, im}
  function automatic logic [5:0] pt4(input logic [3:0] i);
    case (i)
      4'd0: pt4 = {3'sd3, -3'sd3};
      4'd1: pt4 = {-3'sd1, 3'sd1};
      4'd2: pt4 = {-3'sd3, 3'sd3};
      4'd3: pt4 = {3'sd1, -3'sd1};
      4'd4: pt4 = {3'sd3, 3'sd1};
      4'd5: pt4 = {-3'sd1, -3'sd3};
      4'd6: pt4 = {-3'sd3, -3'sd1};
      4'd7: pt4 = {3'sd1, 3'sd3};
      4'd8: pt4 = {-3'sd1, 3'sd3};
      4'd9: pt4 = {3'sd3, -3'sd1};
      4'd10: pt4 = {3'sd1, -3'sd3};
      4'd11: pt4 = {-3'sd3, 3'sd1};
      4'd12: pt4 = {-3'sd3, -3'sd3};
      4'd13: pt4 = {3'sd1, 3'sd1};
      4'd14: pt4 = {3'sd3, 3'sd3};
      default: pt4 = {-3'sd1, -3'sd1};
    endcase
  endfunction

  function automatic logic [5:0] pt2(input logic [1:0] i);
    case (i)
      2'd0: pt2 = {-3'sd3, -3'sd1};
      2'd1: pt2 = {3'sd1, -3'sd3};
      2'd2: pt2 = {-3'sd1, 3'sd3};
      default: pt2 = {3'sd3, 3'sd1};
    endcase
  endfunction

  function automatic logic [2:0] next_state(input logic [2:0] s, input logic [1:0] k);
    logic [11:0] row;
    begin
      case (s)
        3'd0: row = {3'd1, 3'd2, 3'd3, 3'd0};
        3'd1: row = {3'd6, 3'd7, 3'd5, 3'd4};
        3'd2: row = {3'd0, 3'd3, 3'd2, 3'd1};
        3'd3: row = {3'd5, 3'd4, 3'd6, 3'd7};
        3'd4: row = {3'd3, 3'd0, 3'd1, 3'd2};
        3'd5: row = {3'd4, 3'd5, 3'd7, 3'd6};
        3'd6: row = {3'd2, 3'd1, 3'd0, 3'd3};
        default: row = {3'd7, 3'd6, 3'd4, 3'd5};
      endcase
      next_state = row[3*k +: 3];
    end
  endfunction

  function automatic logic [1:0] uncoded_map(input logic [3:0] h);
    logic [31:0] t;
    begin
      t = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0,
           2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1};
      uncoded_map = t[2*h +: 2];
    end
  endfunction

  function automatic logic [1:0] coded_map(input logic [3:0] h);
    logic [31:0] t;
    begin
      t = {2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3,
           2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
      coded_map = t[2*h +: 2];
    end
  endfunction

  function automatic logic [3:0] region_map(input logic [3:0] r);
    logic [63:0] t;
    begin
      t = {4'he, 4'h0, 4'h2, 4'hc, 4'h4, 4'h9, 4'hb, 4'h6,
           4'h7, 4'ha, 4'h8, 4'h5, 4'hd, 4'h3, 4'h1, 4'hf};
      region_map = t[4*r +: 4];
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/v32vd_if.sv
// ----------------------------------------------------------------------------
// v32vd channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface v32vd_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  modport source (output valid, sample_re, sample_im, input ready);
  modport sink (input valid, sample_re, sample_im, output ready);
endinterface

interface v32vd_result_if;
  logic valid;
  logic ready;
  logic [2:0] data_bits;
  logic signed [2:0] point_re;
  logic signed [2:0] point_im;
  modport source (output valid, data_bits, point_re, point_im, input ready);
  modport sink (input valid, data_bits, point_re, point_im, output ready);
endinterface

interface v32vd_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/v32_viterbi_symbol_decoder_core.sv
// ----------------------------------------------------------------------------
// v32_viterbi_symbol_decoder_core
// 4800 uncoded / 7200 trellis coded symbol decoder with 8-state viterbi.
// ----------------------------------------------------------------------------
// channel  dir  word
// smp      in   sample_re, sample_im (q4.11)
// res      out  data_bits, point_re, point_im
// cfg      in   index, data (0 rate_mode, 1 decay_factor)
//
// trellis mode: the single acs unit steps the eight source states one
// per cycle; uncoded mode skips the acs steps.
// sync reset restores survivor lengths and history.
// a stalled result holds the next symbol off until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module v32_viterbi_symbol_decoder_core
  import v32vd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  v32vd_sample_if.sink smp,
  v32vd_result_if.source res,
  v32vd_cfg_if.sink cfg
);
  logic rate_mode;
  logic [7:0] decay_factor;
  logic out_valid;
  logic load_out;
  v32vd_cmd_t cmd;
  v32vd_res_t word;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode <= 1'b0;
      decay_factor <= 8'd253;
    end else if (cfg.valid) begin
      if (cfg.index == 8'(REG_RATE_MODE)) rate_mode <= cfg.data[0];
      else if (cfg.index == 8'(REG_DECAY)) decay_factor <= cfg.data;
    end
  end

  v32vd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(smp.valid), .in_ready(smp.ready),
    .rate_mode, .out_valid, .out_ready(res.ready),
    .load_out, .cmd
  );

  v32vd_dp u_dp (
    .clk, .rst, .cmd,
    .sample_re(smp.sample_re), .sample_im(smp.sample_im),
    .decay_factor, .res(word)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (res.ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (load_out) begin
      res.data_bits <= word.bits;
      res.point_re <= word.pre;
      res.point_im <= word.pim;
    end
  end
  assign res.valid = out_valid;

  a_no_load_stall: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || res.ready)) else $error("result overwritten");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (smp.valid && smp.ready) |=> !smp.ready) else $error("double accept");
  a_one_hot_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.acs_en, cmd.commit})) else $error("cmd overlap");
endmodule
`default_nettype wire

// File: rtl/v32vd_ctrl.sv
// ----------------------------------------------------------------------------
// v32vd_ctrl
// Sequencer: in trellis mode one acs step per source state, then result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module v32vd_ctrl
  import v32vd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic rate_mode,
  input  wire logic out_valid,
  input  wire logic out_ready,
  output logic      load_out,
  output v32vd_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACS = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state, state_next;
  logic [STATE_W-1:0] src, src_next;
  logic coded, coded_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    src_next = src;
    coded_next = coded;
    cmd = '0;
    load_out = 1'b0;
    cmd.src = src;
    cmd.coded = coded;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cmd.coded = rate_mode;
          coded_next = rate_mode;
          src_next = '0;
          state_next = rate_mode ? S_ACS : S_DONE;
        end
      end
      S_ACS: begin
        cmd.acs_en = 1'b1;
        src_next = src + 1'b1;
        if (src == STATE_W'(STATE_COUNT - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      src <= '0;
      coded <= 1'b0;
    end else begin
      state <= state_next;
      src <= src_next;
      coded <= coded_next;
    end
  end
endmodule
`default_nettype wire

// File: rtl/v32vd_dp.sv
// ----------------------------------------------------------------------------
// v32vd_dp
// Branch metrics, shared add-compare-select unit and survivor registers.
// ----------------------------------------------------------------------------
`default_nettype none
module v32vd_dp
  import v32vd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire v32vd_cmd_t cmd,
  input  wire logic signed [15:0] sample_re,
  input  wire logic signed [15:0] sample_im,
  input  wire logic [7:0] decay_factor,
  output v32vd_res_t res
);
  logic [LEN_W-1:0] slen [STATE_COUNT];
  logic [PATH_W-1:0] spath [STATE_COUNT];
  logic [LEN_W-1:0] nlen [STATE_COUNT];
  logic [PATH_W-1:0] npath [STATE_COUNT];
  logic [LEN_W-1:0] metric [8];
  logic low_bit [8];
  logic [3:0] hist;
  logic [3:0] hist_next;
  logic signed [15:0] sre, sim;

  // branch metrics, registered at start
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sre <= sample_re;
      sim <= sample_im;
    end
  end

  logic [DIST_W-1:0] d0 [8];
  logic [DIST_W-1:0] d1 [8];
  always_comb begin
    logic [5:0] a, b;
    logic signed [17:0] dr, di, er, ei;
    for (int j = 0; j < 8; j++) begin
      a = pt4(4'(2*j));
      b = pt4(4'(2*j+1));
      dr = 18'(sample_re) - 18'(signed'(a[5:3])) * 18'sd2048;
      di = 18'(sample_im) - 18'(signed'(a[2:0])) * 18'sd2048;
      er = 18'(sample_re) - 18'(signed'(b[5:3])) * 18'sd2048;
      ei = 18'(sample_im) - 18'(signed'(b[2:0])) * 18'sd2048;
      d0[j] = DIST_W'(dr * dr) + DIST_W'(di * di);
      d1[j] = DIST_W'(er * er) + DIST_W'(ei * ei);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int j = 0; j < 8; j++) begin
        low_bit[j] <= !(d0[j] < d1[j]);
        metric[j] <= (d0[j] < d1[j]) ? LEN_W'(d0[j] >> 14) : LEN_W'(d1[j] >> 14);
      end
    end
  end

  // one source state per cycle: decay then four candidates
  logic [LEN_W-1:0] len_src, dec;
  logic [LEN_W+7:0] prod;
  assign len_src = slen[cmd.src];
  assign prod = len_src * decay_factor;
  assign dec = (len_src == LEN_INF) ? LEN_INF : LEN_W'(prod >> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < STATE_COUNT; j++) begin
        slen[j] <= (j == 0) ? '0 : LEN_INF;
        spath[j] <= '0;
      end
      hist <= '0;
    end else begin
      if (cmd.start) begin
        for (int j = 0; j < STATE_COUNT; j++) begin
          nlen[j] <= LEN_INF;
          npath[j] <= '0;
        end
      end
      if (cmd.acs_en) begin
        logic [LEN_W:0] s;
        logic [LEN_W-1:0] plen;
        logic [2:0] y;
        logic [2:0] base;
        logic [LEN_W-1:0] cl [STATE_COUNT];
        logic [PATH_W-1:0] cp [STATE_COUNT];
        base = {cmd.src[0], 2'b00};
        for (int j = 0; j < STATE_COUNT; j++) begin
          cl[j] = nlen[j];
          cp[j] = npath[j];
        end
        for (int k = 0; k < 4; k++) begin
          y = next_state(cmd.src, 2'(k));
          s = {1'b0, dec} + {1'b0, metric[base + 3'(k)]};
          plen = (dec == LEN_INF || s >= {1'b0, LEN_INF}) ? LEN_INF : s[LEN_W-1:0];
          if (plen < cl[y]) begin
            cl[y] = plen;
            cp[y] = {spath[cmd.src][PATH_W-4:0], 2'(k), low_bit[base + 3'(k)]};
          end
        end
        for (int j = 0; j < STATE_COUNT; j++) begin
          nlen[j] <= cl[j];
          npath[j] <= cp[j];
        end
      end
      if (cmd.commit) begin
        hist <= hist_next;
        if (cmd.coded) begin
          for (int j = 0; j < STATE_COUNT; j++) begin
            slen[j] <= nlen[j];
            spath[j] <= npath[j];
          end
        end
      end
    end
  end

  // result formation
  logic [2:0] r;
  logic b1, b2;
  logic [3:0] reg_sel;
  logic [5:0] pt;
  logic signed [17:0] re2, im2;
  assign r = npath[0][PATH_W-1 -: 3];
  assign re2 = 18'(sre) * 18'sd2;
  assign im2 = 18'(sim) * 18'sd2;
  assign b1 = im2 > -18'(sre);
  assign b2 = re2 > 18'(sim);
  assign reg_sel = {(sre > 16'sd4096) || (sre < -16'sd4096),
                    (sim > 16'sd4096) || (sim < -16'sd4096),
                    sre > 16'sd0, sim > 16'sd0};
  always_comb begin
    if (cmd.coded) begin
      hist_next = {hist[1:0], r[2:1]};
      pt = pt4(region_map(reg_sel));
      res.bits = {coded_map(hist_next), r[0]};
    end else begin
      hist_next = {hist[1:0], b1, b2};
      pt = pt2(hist_next[1:0]);
      res.bits = {1'b0, uncoded_map(hist_next)};
    end
    res.pre = pt[5:3];
    res.pim = pt[2:0];
  end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the trellis symbol decoder against a behavioral predictor in both
// rate modes, over several decay settings, with random idling on the sample and result sides.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import v32vd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [2:0] bits;
    logic signed [2:0] pre;
    logic signed [2:0] pim;
  } decoded_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int mismatch_count = 0;
  int idle_cycles = 0;
  decoded_word_t expected_words[$];

  v32vd_sample_if smp ();
  v32vd_result_if res ();
  v32vd_cfg_if cfg ();

  v32_viterbi_symbol_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .smp(smp),
    .res(res),
    .cfg(cfg)
  );

  // predictor state
  logic pred_coded;
  logic [7:0] pred_decay;
  logic [LEN_W-1:0] path_len[STATE_COUNT];
  logic [PATH_W-1:0] path_bits[STATE_COUNT];
  logic [3:0] pred_hist;

  // tables of the decoder, written out here independently
  function automatic logic signed [2:0] const16(input int i, input bit im);
    int xs[16] = '{3, -1, -3, 1, 3, -1, -3, 1, -1, 3, 1, -3, -3, 1, 3, -1};
    int ys[16] = '{-3, 1, 3, -1, 1, -3, -1, 3, 3, -1, -3, 1, -3, 1, 3, -1};
    return im ? 3'(ys[i]) : 3'(xs[i]);
  endfunction

  function automatic int branch_target(input int s, input int k);
    int tbl[32] = '{0, 3, 2, 1, 4, 5, 7, 6, 1, 2, 3, 0, 7, 6, 4, 5,
                    2, 1, 0, 3, 6, 7, 5, 4, 3, 0, 1, 2, 5, 4, 6, 7};
    return tbl[4 * s + k];
  endfunction

  function automatic longint sq_dist(input int re, input int im, input int pidx);
    longint dr;
    longint di;
    dr = longint'(re) - longint'(const16(pidx, 0)) * 2048;
    di = longint'(im) - longint'(const16(pidx, 1)) * 2048;
    return dr * dr + di * di;
  endfunction

  function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = a + b;
    return (a == LEN_INF || s >= LEN_INF) ? LEN_INF : s[LEN_W-1:0];
  endfunction

  task automatic predict_symbol(input logic signed [15:0] re,
                                input logic signed [15:0] im);
    int unc_tbl[16] = '{1, 0, 3, 2, 3, 1, 2, 0, 0, 2, 1, 3, 2, 3, 0, 1};
    int cod_tbl[16] = '{0, 1, 2, 3, 1, 0, 3, 2, 3, 2, 0, 1, 2, 3, 1, 0};
    int reg_tbl[16] = '{15, 1, 3, 13, 5, 8, 10, 7, 6, 11, 9, 4, 12, 2, 0, 14};
    int p2x[4] = '{-3, 1, -1, 3};
    int p2y[4] = '{-1, -3, 3, 1};
    int ri;
    int ii;
    logic [LEN_W-1:0] metric[8];
    logic lsb[8];
    logic [LEN_W-1:0] nlen[STATE_COUNT];
    logic [PATH_W-1:0] npath[STATE_COUNT];
    logic [LEN_W-1:0] dec;
    logic [LEN_W-1:0] plen;
    longint d0;
    longint d1;
    longint dm;
    int y;
    int base;
    int rgn;
    logic [2:0] r;
    decoded_word_t w;
    ri = re;
    ii = im;
    if (!pred_coded) begin
      pred_hist = {pred_hist[1:0], (2 * ii > -ri), (2 * ri > ii)};
      w.bits = 3'(unc_tbl[pred_hist]);
      w.pre = 3'(p2x[pred_hist[1:0]]);
      w.pim = 3'(p2y[pred_hist[1:0]]);
    end else begin
      for (int j = 0; j < 8; j++) begin
        d0 = sq_dist(ri, ii, 2 * j);
        d1 = sq_dist(ri, ii, 2 * j + 1);
        dm = (d0 < d1) ? d0 : d1;
        lsb[j] = !(d0 < d1);
        metric[j] = LEN_W'(dm >> 14);
        nlen[j] = LEN_INF;
        npath[j] = '0;
      end
      for (int s = 0; s < STATE_COUNT; s++) begin
        base = (s & 1) * 4;
        dec = (path_len[s] == LEN_INF) ? LEN_INF :
              LEN_W'((longint'(path_len[s]) * pred_decay) >> 8);
        for (int k = 0; k < 4; k++) begin
          y = branch_target(s, k);
          plen = len_add(dec, metric[base + k]);
          if (plen < nlen[y]) begin
            nlen[y] = plen;
            npath[y] = {path_bits[s][PATH_W-4:0], 2'(k), lsb[base + k]};
          end
        end
      end
      for (int s = 0; s < STATE_COUNT; s++) begin
        path_len[s] = nlen[s];
        path_bits[s] = npath[s];
      end
      r = path_bits[0][PATH_W-1 -: 3];
      pred_hist = {pred_hist[1:0], r[2:1]};
      w.bits = {2'(cod_tbl[pred_hist]), r[0]};
      rgn = ((ri > 4096 || ri < -4096) ? 8 : 0) | ((ii > 4096 || ii < -4096) ? 4 : 0)
          | ((ri > 0) ? 2 : 0) | ((ii > 0) ? 1 : 0);
      w.pre = const16(reg_tbl[rgn], 0);
      w.pim = const16(reg_tbl[rgn], 1);
    end
    expected_words.push_back(w);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    smp.valid = 1'b0;
    smp.sample_re = '0;
    smp.sample_im = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    res.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // result checker with random stall on ready
  initial begin
    int stall;
    decoded_word_t w;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = expected_words.pop_front();
        if (res.data_bits !== w.bits) report_mismatch("data_bits", res.data_bits, w.bits);
        if (res.point_re !== w.pre) report_mismatch("point_re", res.point_re, w.pre);
        if (res.point_im !== w.pim) report_mismatch("point_im", res.point_im, w.pim);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // valid stays high after an accepted word until the next gap or idle phase
  task automatic send_symbol(input logic signed [15:0] re, input logic signed [15:0] im);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample_re <= re;
    smp.sample_im <= im;
    do @(posedge clk); while (!smp.ready);
    predict_symbol(re, im);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    smp.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == 8'(REG_RATE_MODE)) pred_coded = value[0];
    else if (idx == 8'(REG_DECAY)) pred_decay = value;
  endtask

  // a point near a constellation point, with noise of random spread
  task automatic send_near_point();
    int pidx;
    int spread;
    pidx = $urandom_range(0, 15);
    spread = $urandom_range(0, 2) == 0 ? 3000 : 600;
    send_symbol(16'(int'(const16(pidx, 0)) * 2048 + $urandom_range(0, 2 * spread) - spread),
                16'(int'(const16(pidx, 1)) * 2048 + $urandom_range(0, 2 * spread) - spread));
  endtask

  task automatic send_random_run(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) send_symbol(16'($urandom), 16'($urandom));
      else send_near_point();
    end
  endtask

  task automatic test_uncoded_directed();
    int vals[8] = '{-32768, 32767, 0, -1, 1, 4096, -4097, 2048};
    for (int i = 0; i < 8; i++) send_symbol(16'(vals[i]), 16'(vals[7 - i]));
    send_symbol(16'sd4096, -16'sd2048);
    send_symbol(-16'sd4096, 16'sd2048);
  endtask

  task automatic test_trellis_directed();
    write_reg(8'(REG_RATE_MODE), 8'd1);
    send_symbol(16'sh7fff, 16'sh7fff);
    send_symbol(-16'sd32768, -16'sd32768);
    send_symbol(16'sd0, 16'sd0);
    send_symbol(16'sd4096, 16'sd4097);
    send_symbol(-16'sd4096, -16'sd4097);
    send_symbol(16'sd4097, -16'sd1);
    send_symbol(16'sd1, 16'sd4096);
    for (int i = 0; i < 10; i++) send_near_point();
  endtask

  task automatic test_decay_settings();
    write_reg(8'(REG_DECAY), 8'd0);
    send_random_run(120);
    write_reg(8'(REG_DECAY), 8'd255);
    send_random_run(200);
    write_reg(8'(REG_DECAY), 8'($urandom_range(200, 254)));
    send_random_run(150);
  endtask

  task automatic test_mode_switching();
    write_reg(8'(REG_RATE_MODE), 8'd0);
    send_random_run(100);
    write_reg(8'(REG_RATE_MODE), 8'hff);
    write_reg(8'(REG_DECAY), 8'd253);
    send_random_run(200);
    // index past the register list is ignored
    write_reg(8'd2, 8'h00);
    write_reg(8'hff, 8'h00);
    send_random_run(60);
    write_reg(8'(REG_RATE_MODE), 8'hfe);
    send_random_run(80);
  endtask

  initial begin
    pred_coded = 1'b0;
    pred_decay = 8'd253;
    pred_hist = '0;
    for (int s = 0; s < STATE_COUNT; s++) begin
      path_len[s] = (s == 0) ? '0 : LEN_INF;
      path_bits[s] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uncoded_directed();
    test_trellis_directed();
    test_decay_settings();
    test_mode_switching();
    smp.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
